/* hdl/hccf_pkg.sv */
package hccf_pkg;

  // Fixed field widths of the item and result.
  localparam int ID_BITS      = 16;
  localparam int COUNTER_BITS = 2;
  localparam int WORD_BITS    = 32;
  localparam int PER_WORD     = WORD_BITS / COUNTER_BITS;
  localparam int SLOT_BITS    = $clog2(PER_WORD);
  // Number of counter words that a 16-bit record id can reach.
  localparam int ID_WORDS     = (1 << ID_BITS) / PER_WORD;

  // Queue between the classifier and the executor.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Item opcodes.
  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_HIT_THRESHOLD_MODE = 1'b0;

  typedef struct packed {
    logic               opcode;
    logic [ID_BITS-1:0] rec_id;
  } item_t;

  typedef struct packed {
    logic                    is_candidate;
    logic [ID_BITS-1:0]      hit_record;
    logic [COUNTER_BITS-1:0] count_after;
  } result_t;

  typedef enum logic [1:0] {
    KIND_HIT,
    KIND_PASS,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_BITS-1:0] rec_id;
  } q_item_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MODIFY
  } back_state_t;

endpackage

/* hdl/hit_count_candidate_filter.sv */
// Hit-count candidate filter. Items arrive on the item channel (item_valid,
// item_stall, item) and each one produces exactly one transfer on the result
// channel (result_valid, result_stall, result). A hit item advances the 2-bit
// counter of its record up to the threshold that hit_threshold_mode selects
// and reports whether it just reached it; a clear item zeroes the counter
// words touched since the previous clear.
// In the executor a hit first reads its counter word from the store (ST_IDLE),
// then updates it and registers the result (ST_MODIFY); the executor starts
// no new item until the hit is done. Out-of-range ids and clears are done in ST_IDLE.
// A clear also occupies the executor while it sweeps the dirty words to zero,
// from the lowest to the highest word written since the last clear.
// A hit passes through the queue, then ST_IDLE and ST_MODIFY, before its
// result is registered for the receiver. A two-entry queue sits between the
// classifier and the executor, so items keep being taken, until the queue is
// full, while the executor is busy or the result waits.
// After reset the whole counter store is swept to zero, one word per cycle
// (MEM_WORDS words, at most 4096); item_stall stays high during that time.
// When the receiver stalls, the registered result holds and the executor
// waits before starting the next item. The configuration register is
// written through the APB port at byte address 0.
module hit_count_candidate_filter import hccf_pkg::*; #(
  parameter int RECORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    hit_threshold_mode;
  logic    init_busy;
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // The register index is the word address; the byte offset is ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HIT_THRESHOLD_MODE) ? {31'b0, hit_threshold_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_HIT_THRESHOLD_MODE)) begin
      hit_threshold_mode <= pwdata[0];
    end
  end

  // Classifier and queue: sorts each item into hit, out-of-range or clear.
  hccf_front #(
    .RECORDS(RECORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (init_busy),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Executor: owns the counter store, the dirty range and the result register.
  hccf_back #(
    .RECORDS(RECORDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mode        (hit_threshold_mode),
    .init_busy   (init_busy),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

/* hdl/hccf_front.sv */
module hccf_front import hccf_pkg::*; #(
  parameter int RECORDS = 65536
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    hold,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    q_pop
);

  q_item_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  q_item_t                classified;
  logic                   push;
  logic                   pop;

  // Sort each item: a clear, a hit on a tracked record, or an id that is
  // out of range and is only echoed.
  always_comb begin
    classified.rec_id = item.rec_id;
    if (item.opcode == OP_CLEAR) begin
      classified.kind = KIND_CLEAR;
    end else if (32'(item.rec_id) < 32'(RECORDS)) begin
      classified.kind = KIND_HIT;
    end else begin
      classified.kind = KIND_PASS;
    end
  end

  assign item_stall = hold || (count == QCNT_BITS'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign pop        = q_pop && q_valid;
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

endmodule

/* hdl/hccf_back.sv */
module hccf_back import hccf_pkg::*; #(
  parameter int RECORDS = 65536
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    mode,
  output logic    init_busy,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int WORDS     = (RECORDS + PER_WORD - 1) / PER_WORD;
  localparam int MEM_WORDS = (WORDS < ID_WORDS) ? WORDS : ID_WORDS;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

  logic [WORD_BITS-1:0] mem [MEM_WORDS];

  back_state_t          state, state_next;
  logic                 init_pass, init_pass_next;
  logic [AW-1:0]        sweep_addr, sweep_addr_next;
  logic [AW-1:0]        sweep_end, sweep_end_next;
  logic                 any_dirty, any_dirty_next;
  logic [AW-1:0]        lowest_dirty, lowest_dirty_next;
  logic [AW-1:0]        highest_dirty, highest_dirty_next;
  logic [ID_BITS-1:0]   cur_id, cur_id_next;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 we;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic                    out_free;
  logic                    push;
  result_t                 push_data;
  logic [AW-1:0]           cur_word;
  logic [SLOT_BITS-1:0]    cur_slot;
  logic [COUNTER_BITS-1:0] cnt;
  logic [COUNTER_BITS-1:0] lim;
  logic                    below;
  logic [COUNTER_BITS-1:0] cnt_new;
  logic [WORD_BITS-1:0]    new_word;

  assign init_busy = init_pass;
  assign out_free  = !result_valid || !result_stall;
  assign cur_word  = cur_id[SLOT_BITS +: AW];
  assign cur_slot  = cur_id[SLOT_BITS-1:0];

  // Counter update for the word that was read in the previous cycle.
  always_comb begin
    cnt      = rd_data[{cur_slot, 1'b0} +: COUNTER_BITS];
    lim      = mode ? 2'd3 : 2'd2;
    below    = (cnt < lim);
    cnt_new  = below ? cnt + 1'b1 : cnt;
    new_word = rd_data;
    new_word[{cur_slot, 1'b0} +: COUNTER_BITS] = cnt_new;
  end

  always_comb begin
    state_next         = state;
    init_pass_next     = init_pass;
    sweep_addr_next    = sweep_addr;
    sweep_end_next     = sweep_end;
    any_dirty_next     = any_dirty;
    lowest_dirty_next  = lowest_dirty;
    highest_dirty_next = highest_dirty;
    cur_id_next        = cur_id;
    q_pop              = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = q_item.rec_id[SLOT_BITS +: AW];
    we                 = 1'b0;
    wr_addr            = sweep_addr;
    wr_data            = '0;
    push               = 1'b0;
    push_data          = '0;

    unique case (state)
      ST_SWEEP: begin
        we = 1'b1;
        if (sweep_addr == sweep_end) begin
          state_next     = ST_IDLE;
          init_pass_next = 1'b0;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_valid && out_free) begin
          unique case (q_item.kind)
            KIND_HIT: begin
              q_pop       = 1'b1;
              rd_en       = 1'b1;
              cur_id_next = q_item.rec_id;
              state_next  = ST_MODIFY;
            end
            KIND_PASS: begin
              q_pop                = 1'b1;
              push                 = 1'b1;
              push_data.hit_record = q_item.rec_id;
            end
            KIND_CLEAR: begin
              q_pop = 1'b1;
              push  = 1'b1;
              if (any_dirty) begin
                sweep_addr_next    = lowest_dirty;
                sweep_end_next     = highest_dirty;
                any_dirty_next     = 1'b0;
                lowest_dirty_next  = '0;
                highest_dirty_next = '0;
                state_next         = ST_SWEEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MODIFY: begin
        push                   = 1'b1;
        push_data.is_candidate = below && (cnt_new == lim);
        push_data.hit_record   = cur_id;
        push_data.count_after  = cnt_new;
        if (below) begin
          we      = 1'b1;
          wr_addr = cur_word;
          wr_data = new_word;
          if (!any_dirty) begin
            any_dirty_next     = 1'b1;
            lowest_dirty_next  = cur_word;
            highest_dirty_next = cur_word;
          end else begin
            if (cur_word < lowest_dirty) begin
              lowest_dirty_next = cur_word;
            end
            if (cur_word > highest_dirty) begin
              highest_dirty_next = cur_word;
            end
          end
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      init_pass     <= 1'b1;
      sweep_addr    <= '0;
      sweep_end     <= LAST_WORD;
      any_dirty     <= 1'b0;
      lowest_dirty  <= '0;
      highest_dirty <= '0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      init_pass     <= init_pass_next;
      sweep_addr    <= sweep_addr_next;
      sweep_end     <= sweep_end_next;
      any_dirty     <= any_dirty_next;
      lowest_dirty  <= lowest_dirty_next;
      highest_dirty <= highest_dirty_next;
      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_id <= cur_id_next;
    if (push) begin
      result <= push_data;
    end
  end

  // Counter store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
